>>> rtl/single_wire_pulse_width_command_tx_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-wire command transmitter
// Concurrent checks that are clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_PULSE_WIDTH_COMMAND_TX_TOP_ASSERT_SVH
`define SINGLE_WIRE_PULSE_WIDTH_COMMAND_TX_TOP_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define SWPWTX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the condition holds, the consequence must hold in the following cycle.
`define SWPWTX_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) else $error(msg);

`endif

>>> rtl/swpwtx_pkg.sv
// ----------------------------------------------------------------------------
// swpwtx_pkg
// Types and constants of the single-wire pulse-width command transmitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swpwtx_pkg;

  localparam int unsigned LevelW = 8;
  localparam int unsigned TimeW  = 10;
  localparam int unsigned DurW   = 12;
  localparam int unsigned IdxW   = 6;

  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_SET     = 2'd0;
  localparam req_type_t REQ_DETECT  = 2'd1;
  localparam req_type_t REQ_SUSPEND = 2'd2;
  localparam req_type_t REQ_RESUME  = 2'd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_MAX_LEVEL    = 3'd0;
  localparam reg_idx_t REG_START_TIME   = 3'd1;
  localparam reg_idx_t REG_END_TIME     = 3'd2;
  localparam reg_idx_t REG_SHORT_TIME   = 3'd3;
  localparam reg_idx_t REG_DETECT_DELAY = 3'd4;
  localparam reg_idx_t REG_DETECT_LOW   = 3'd5;

  localparam logic [LevelW-1:0] RST_MAX_LEVEL    = 8'd255;
  localparam logic [TimeW-1:0]  RST_START_TIME   = 10'd3;
  localparam logic [TimeW-1:0]  RST_END_TIME     = 10'd3;
  localparam logic [TimeW-1:0]  RST_SHORT_TIME   = 10'd3;
  localparam logic [DurW-1:0]   RST_DETECT_DELAY = 12'd120;
  localparam logic [DurW-1:0]   RST_DETECT_LOW   = 12'd280;

  localparam logic [LevelW-1:0] CMD_SET_BYTE = 8'h72;

  // Segment index: detect high, detect low, 36 byte segments, hold high.
  localparam logic [IdxW-1:0] IDX_DET_HIGH  = 6'd0;
  localparam logic [IdxW-1:0] IDX_DET_LOW   = 6'd1;
  localparam logic [IdxW-1:0] IDX_BYTE_BASE = 6'd2;
  localparam logic [IdxW-1:0] IDX_HOLD      = 6'd38;
  localparam logic [IdxW-1:0] SEGS_PER_BYTE = 6'd18;
  localparam logic [4:0]      BYTE_LAST_J   = 5'd17;

endpackage

`default_nettype wire

>>> rtl/single_wire_pulse_width_command_tx_top.sv
// ----------------------------------------------------------------------------
// single_wire_pulse_width_command_tx_top
// Turns light-control requests into timed wire segments for a single-wire
// pulse-width link, one segment per output transaction.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser req_type, tdata level_req
// m_axis    out  m_axis_tvalid/tready      tdata segment fields, tlast last
// cfg       in   cfg_we_i                  cfg_addr_i index, cfg_wdata_i value
//
// A request yields 3 to 39 segments, one per unstalled cycle from the counter.
// The next request is taken in the cycle that the hold segment is produced.
// The output register holds a segment while m_axis_tready is low; the
// segment counter stops until it is taken.
// Reset clears the configuration to its defaults and the brightness to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "single_wire_pulse_width_command_tx_top_assert.svh"

module single_wire_pulse_width_command_tx_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] level_req
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [0] line_level, [12:1] duration_us,
                                          // [13] line_enable, [21:14] level_now
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [11:0] cfg_wdata_i
);

  localparam int unsigned LW = swpwtx_pkg::LevelW;
  localparam int unsigned TW = swpwtx_pkg::TimeW;
  localparam int unsigned DW = swpwtx_pkg::DurW;
  localparam int unsigned IW = swpwtx_pkg::IdxW;

  logic [LW-1:0] max_level_q;
  logic [TW-1:0] start_time_q, end_time_q, short_time_q;
  logic [DW-1:0] detect_delay_q, detect_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q    <= swpwtx_pkg::RST_MAX_LEVEL;
      start_time_q   <= swpwtx_pkg::RST_START_TIME;
      end_time_q     <= swpwtx_pkg::RST_END_TIME;
      short_time_q   <= swpwtx_pkg::RST_SHORT_TIME;
      detect_delay_q <= swpwtx_pkg::RST_DETECT_DELAY;
      detect_low_q   <= swpwtx_pkg::RST_DETECT_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        swpwtx_pkg::REG_MAX_LEVEL:    max_level_q    <= cfg_wdata_i[LW-1:0];
        swpwtx_pkg::REG_START_TIME:   start_time_q   <= cfg_wdata_i[TW-1:0];
        swpwtx_pkg::REG_END_TIME:     end_time_q     <= cfg_wdata_i[TW-1:0];
        swpwtx_pkg::REG_SHORT_TIME:   short_time_q   <= cfg_wdata_i[TW-1:0];
        swpwtx_pkg::REG_DETECT_DELAY: detect_delay_q <= cfg_wdata_i;
        swpwtx_pkg::REG_DETECT_LOW:   detect_low_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request state and the request being sent.
  logic [LW-1:0] level_q, level_d, saved_q, saved_d;
  logic          line_on_q, line_on_d;
  logic          active_q, active_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic          body_en_q, body_en_d, hold_en_q, hold_en_d;
  logic          is_det_q, is_det_d;

  logic          accept, fire, seg_last;
  logic [LW-1:0] clamp_in, clamp_saved;
  logic [IW-1:0] start_idx;

  assign fire          = active_q && (!m_axis_tvalid || m_axis_tready);
  assign seg_last      = (idx_q == swpwtx_pkg::IDX_HOLD);
  assign s_axis_tready = !active_q || (fire && seg_last);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (s_axis_tdata[15]) begin
      clamp_in = '0;
    end else if (s_axis_tdata > {8'd0, max_level_q}) begin
      clamp_in = max_level_q;
    end else begin
      clamp_in = s_axis_tdata[LW-1:0];
    end
    clamp_saved = (saved_q > max_level_q) ? max_level_q : saved_q;
  end

  always_comb begin
    level_d   = level_q;
    saved_d   = saved_q;
    line_on_d = line_on_q;
    lvl_d     = lvl_q;
    body_en_d = body_en_q;
    hold_en_d = hold_en_q;
    is_det_d  = is_det_q;
    start_idx = swpwtx_pkg::IDX_BYTE_BASE;
    unique case (s_axis_tuser)
      swpwtx_pkg::REQ_SET: begin
        lvl_d     = clamp_in;
        body_en_d = line_on_q;
        hold_en_d = line_on_q;
        is_det_d  = 1'b0;
      end
      swpwtx_pkg::REQ_DETECT: begin
        lvl_d     = level_q;
        body_en_d = line_on_q;
        hold_en_d = line_on_q;
        is_det_d  = 1'b1;
        start_idx = swpwtx_pkg::IDX_DET_HIGH;
      end
      swpwtx_pkg::REQ_SUSPEND: begin
        saved_d   = level_q;
        lvl_d     = '0;
        body_en_d = line_on_q;
        hold_en_d = 1'b0;
        line_on_d = 1'b0;
        is_det_d  = 1'b0;
      end
      swpwtx_pkg::REQ_RESUME: begin
        lvl_d     = clamp_saved;
        body_en_d = 1'b1;
        hold_en_d = 1'b1;
        line_on_d = 1'b1;
        is_det_d  = 1'b0;
        start_idx = swpwtx_pkg::IDX_DET_HIGH;
      end
      default: ;
    endcase
    level_d = lvl_d;
  end

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    if (fire) begin
      if (seg_last) begin
        active_d = 1'b0;
      end else if (is_det_q && idx_q == swpwtx_pkg::IDX_DET_LOW) begin
        idx_d = swpwtx_pkg::IDX_HOLD;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (accept) begin
      active_d = 1'b1;
      idx_d    = start_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      saved_q   <= '0;
      line_on_q <= 1'b1;
      active_q  <= 1'b0;
      idx_q     <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      if (accept) begin
        level_q   <= level_d;
        saved_q   <= saved_d;
        line_on_q <= line_on_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lvl_q     <= lvl_d;
      body_en_q <= body_en_d;
      hold_en_q <= hold_en_d;
      is_det_q  <= is_det_d;
    end
  end

  // Segment decode for the current index.
  logic [IW-1:0] k_idx, j_full;
  logic          second;
  logic [4:0]    j, bpos;
  logic [LW-1:0] cur_byte, shifted;
  logic [DW-1:0] short_dur, long_dur;
  logic          seg_level, seg_en;
  logic [DW-1:0] seg_dur;

  always_comb begin
    k_idx     = idx_q - swpwtx_pkg::IDX_BYTE_BASE;
    second    = (k_idx >= swpwtx_pkg::SEGS_PER_BYTE);
    j_full    = second ? (k_idx - swpwtx_pkg::SEGS_PER_BYTE) : k_idx;
    j         = j_full[4:0];
    bpos      = j - 5'd1;
    cur_byte  = second ? lvl_q : swpwtx_pkg::CMD_SET_BYTE;
    shifted   = cur_byte << bpos[3:1];
    short_dur = {2'b00, short_time_q};
    long_dur  = {1'b0, short_time_q, 1'b0} + {2'b00, short_time_q};
    seg_en    = seg_last ? hold_en_q : body_en_q;
    priority if (idx_q == swpwtx_pkg::IDX_DET_HIGH) begin
      seg_level = 1'b1;
      seg_dur   = detect_delay_q;
    end else if (idx_q == swpwtx_pkg::IDX_DET_LOW) begin
      seg_level = 1'b0;
      seg_dur   = detect_low_q;
    end else if (seg_last) begin
      seg_level = 1'b1;
      seg_dur   = '0;
    end else if (j == 5'd0) begin
      seg_level = 1'b1;
      seg_dur   = {2'b00, start_time_q};
    end else if (j == swpwtx_pkg::BYTE_LAST_J) begin
      seg_level = 1'b0;
      seg_dur   = {2'b00, end_time_q};
    end else begin
      seg_level = bpos[0];
      if (bpos[0] ^ shifted[LW-1]) begin
        seg_dur = short_dur;
      end else begin
        seg_dur = long_dur;
      end
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {2'b00, lvl_q, seg_en, seg_dur, seg_level};
      out_last_q <= seg_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `SWPWTX_ASSERT(a_idx_range, clk_i, rst_ni, !active_q || idx_q <= swpwtx_pkg::IDX_HOLD,
    "segment index beyond the hold segment")
  `SWPWTX_ASSERT(a_last_is_hold, clk_i, rst_ni,
    !(m_axis_tvalid && m_axis_tlast) || (m_axis_tdata[0] && m_axis_tdata[12:1] == 12'd0),
    "final segment is not a hold-high segment")
  `SWPWTX_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, active_q,
    "accepted request did not start the segment counter")

endmodule

`default_nettype wire
